### rtl/voxel_neighborhood_surface_query_assert.svh
// assertion macros for the voxel neighborhood surface query block
// used by rtl/voxel_neighborhood_surface_query.sv, expects clk and rst in scope
`ifndef VOXEL_NEIGHBORHOOD_SURFACE_QUERY_ASSERT_SVH
`define VOXEL_NEIGHBORHOOD_SURFACE_QUERY_ASSERT_SVH

// condition holds at every edge out of reset
`define VNSQ_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// same-cycle implication
`define VNSQ_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VNSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/vnsq_pkg.sv
// shared constants, types and microcode table of the voxel surface query block
// no dependencies; imported by rtl/voxel_neighborhood_surface_query.sv
package vnsq_pkg;

  localparam int GRID_X_MAX     = 16;
  localparam int GRID_Y_MAX     = 16;
  localparam int GRID_Z_MAX     = 16;
  localparam int COMPONENT_BITS = 16;

  localparam int COORD_W      = 5;
  localparam int CFG_W        = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int OCC_W        = 8;
  localparam int COMP_PORT_W  = 16;
  localparam int COMP_W       = (COMPONENT_BITS < COMP_PORT_W) ? COMPONENT_BITS : COMP_PORT_W;
  localparam int WORD_W       = OCC_W + COMP_W;
  localparam int STORE_DEPTH  = GRID_X_MAX * GRID_Y_MAX * GRID_Z_MAX;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int NCOORD_W     = COORD_W + 2;
  localparam int DIFF_W       = 3;
  localparam int STEP_W       = 5;
  localparam int UCODE_DEPTH  = 1 << STEP_W;

  localparam logic [CFG_W-1:0] CELLS_RESET = CFG_W'(16);
  localparam logic [OCC_W-1:0] OCC_HALF    = OCC_W'(128);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // neighbor offsets along one axis
  localparam logic signed [1:0] D_NEG  = -2'sd1;
  localparam logic signed [1:0] D_ZERO = 2'sd0;
  localparam logic signed [1:0] D_POS  = 2'sd1;

  // program entry points
  localparam logic [STEP_W-1:0] STEP_DISPATCH = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_FINISH   = STEP_W'(28);

  typedef enum logic [1:0] {
    OCC_EMPTY,
    OCC_UNKNOWN,
    OCC_FILLED
  } occ_class_t;

  typedef enum logic [1:0] {
    OP_DISPATCH,
    OP_READ,
    OP_NOP,
    OP_FINISH
  } op_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  typedef struct packed {
    op_t                op;
    logic signed [1:0]  dx;
    logic signed [1:0]  dy;
    logic signed [1:0]  dz;
    logic               face;
    logic [STEP_W-1:0]  target;
  } uword_t;

  function automatic occ_class_t occ_class(input logic [OCC_W-1:0] occ);
    occ_class_t c;
    if (occ < OCC_HALF) c = OCC_EMPTY;
    else if (occ == OCC_HALF) c = OCC_UNKNOWN;
    else c = OCC_FILLED;
    return c;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'((ADDR_W'(x) * ADDR_W'(GRID_Y_MAX) + ADDR_W'(y)) * ADDR_W'(GRID_Z_MAX)
                + ADDR_W'(z));
    return a;
  endfunction

  function automatic uword_t uw(input op_t op, input logic signed [1:0] dx,
                                input logic signed [1:0] dy, input logic signed [1:0] dz,
                                input logic face, input logic [STEP_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.dx     = dx;
    w.dy     = dy;
    w.dz     = dz;
    w.face   = face;
    w.target = target;
    return w;
  endfunction

  // control store: center read, 26 neighbor reads, drain, finish
  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    case (step)
      5'd0:  w = uw(OP_DISPATCH, D_ZERO, D_ZERO, D_ZERO, 1'b0, STEP_FINISH);
      5'd1:  w = uw(OP_READ, D_NEG,  D_NEG,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd2:  w = uw(OP_READ, D_NEG,  D_NEG,  D_ZERO, 1'b0, STEP_DISPATCH);
      5'd3:  w = uw(OP_READ, D_NEG,  D_NEG,  D_POS,  1'b0, STEP_DISPATCH);
      5'd4:  w = uw(OP_READ, D_NEG,  D_ZERO, D_NEG,  1'b0, STEP_DISPATCH);
      5'd5:  w = uw(OP_READ, D_NEG,  D_ZERO, D_ZERO, 1'b1, STEP_DISPATCH);
      5'd6:  w = uw(OP_READ, D_NEG,  D_ZERO, D_POS,  1'b0, STEP_DISPATCH);
      5'd7:  w = uw(OP_READ, D_NEG,  D_POS,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd8:  w = uw(OP_READ, D_NEG,  D_POS,  D_ZERO, 1'b0, STEP_DISPATCH);
      5'd9:  w = uw(OP_READ, D_NEG,  D_POS,  D_POS,  1'b0, STEP_DISPATCH);
      5'd10: w = uw(OP_READ, D_ZERO, D_NEG,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd11: w = uw(OP_READ, D_ZERO, D_NEG,  D_ZERO, 1'b1, STEP_DISPATCH);
      5'd12: w = uw(OP_READ, D_ZERO, D_NEG,  D_POS,  1'b0, STEP_DISPATCH);
      5'd13: w = uw(OP_READ, D_ZERO, D_ZERO, D_NEG,  1'b1, STEP_DISPATCH);
      5'd14: w = uw(OP_READ, D_ZERO, D_ZERO, D_POS,  1'b1, STEP_DISPATCH);
      5'd15: w = uw(OP_READ, D_ZERO, D_POS,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd16: w = uw(OP_READ, D_ZERO, D_POS,  D_ZERO, 1'b1, STEP_DISPATCH);
      5'd17: w = uw(OP_READ, D_ZERO, D_POS,  D_POS,  1'b0, STEP_DISPATCH);
      5'd18: w = uw(OP_READ, D_POS,  D_NEG,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd19: w = uw(OP_READ, D_POS,  D_NEG,  D_ZERO, 1'b0, STEP_DISPATCH);
      5'd20: w = uw(OP_READ, D_POS,  D_NEG,  D_POS,  1'b0, STEP_DISPATCH);
      5'd21: w = uw(OP_READ, D_POS,  D_ZERO, D_NEG,  1'b0, STEP_DISPATCH);
      5'd22: w = uw(OP_READ, D_POS,  D_ZERO, D_ZERO, 1'b1, STEP_DISPATCH);
      5'd23: w = uw(OP_READ, D_POS,  D_ZERO, D_POS,  1'b0, STEP_DISPATCH);
      5'd24: w = uw(OP_READ, D_POS,  D_POS,  D_NEG,  1'b0, STEP_DISPATCH);
      5'd25: w = uw(OP_READ, D_POS,  D_POS,  D_ZERO, 1'b0, STEP_DISPATCH);
      5'd26: w = uw(OP_READ, D_POS,  D_POS,  D_POS,  1'b0, STEP_DISPATCH);
      5'd27: w = uw(OP_NOP,  D_ZERO, D_ZERO, D_ZERO, 1'b0, STEP_DISPATCH);
      default: w = uw(OP_FINISH, D_ZERO, D_ZERO, D_ZERO, 1'b0, STEP_DISPATCH);
    endcase
    return w;
  endfunction

endpackage

### rtl/voxel_neighborhood_surface_query.sv
// top level of the voxel neighborhood surface query block
// depends on rtl/vnsq_pkg.sv, rtl/vnsq_ram.sv and voxel_neighborhood_surface_query_assert.svh
//
// usage
//   input channel (in_valid/in_ready): one beat is a command with a cell index.
//   a write beat stores occupancy and component of an in-grid cell; a query beat
//   reads the cell and its 26 neighbors and reports the surface flags.
//   output channel (out_valid/out_ready): exactly one result beat per input beat.
//   config channel (cfg_valid/cfg_ready, always ready): sets cells_x/y/z; the user must
//   write only while the block is idle, unenforced; values above grid maximum saturate.
// timing
//   a query walks a 29-step control program, one single-port ram access a step
//   (center, 26 neighbors, drain, finish); a new beat is accepted only when the
//   block is idle again, after the result is registered. a write or an out-of-grid
//   query skips to the finish step. the single voxel ram port sets the rate.
// reset
//   the control state and the output valid clear, the cell counts return to 16.
//   the voxel ram is not cleared; unwritten cells read as garbage.
// stall
//   the result sits in an output register; a new beat is taken while it waits,
//   and the program holds at its finish step until the register is free.
module voxel_neighborhood_surface_query import vnsq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // input beats
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   command,
  input  logic [COORD_W-1:0]     cell_x,
  input  logic [COORD_W-1:0]     cell_y,
  input  logic [COORD_W-1:0]     cell_z,
  input  logic [OCC_W-1:0]       occupancy_in,
  input  logic [COMP_PORT_W-1:0] component_in,
  // result beats
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   in_grid,
  output logic                   occupancy_surface,
  output logic                   component_surface,
  output logic                   candidate_corner,
  output logic [DIFF_W-1:0]      differing_faces,
  // config writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // configuration registers
  logic [CFG_W-1:0] cells_x;
  logic [CFG_W-1:0] cells_y;
  logic [CFG_W-1:0] cells_z;
  logic [CFG_W-1:0] lim_x;
  logic [CFG_W-1:0] lim_y;
  logic [CFG_W-1:0] lim_z;

  // sequencer
  state_t            state;
  state_t            state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            uword;
  logic              in_fire;
  logic              finish_go;

  // latched item
  logic               cmd_q;
  logic [COORD_W-1:0] x_q;
  logic [COORD_W-1:0] y_q;
  logic [COORD_W-1:0] z_q;
  logic [OCC_W-1:0]   occ_q;
  logic [COMP_W-1:0]  comp_q;

  // neighbor address path
  logic signed [NCOORD_W-1:0] nx;
  logic signed [NCOORD_W-1:0] ny;
  logic signed [NCOORD_W-1:0] nz;
  logic                       n_inside;
  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_addr;
  logic [WORD_W-1:0]          ram_wdata;
  logic [WORD_W-1:0]          ram_rdata;

  // evaluation stage, in the cycle after the ram access
  logic              ev_valid;
  logic              ev_center;
  logic              ev_face;
  logic              ev_inside;
  occ_class_t        rd_class;
  logic [COMP_W-1:0] rd_comp;

  // accumulators
  logic              ing_q;
  occ_class_t        my_class;
  logic [COMP_W-1:0] my_comp;
  logic              occ_surf_q;
  logic              comp_surf_q;
  logic [DIFF_W-1:0] diff_q;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  // saturate the cell counts to the grid size
  assign lim_x = (9'(cells_x) > 9'(GRID_X_MAX)) ? CFG_W'(GRID_X_MAX) : cells_x;
  assign lim_y = (9'(cells_y) > 9'(GRID_Y_MAX)) ? CFG_W'(GRID_Y_MAX) : cells_y;
  assign lim_z = (9'(cells_z) > 9'(GRID_Z_MAX)) ? CFG_W'(GRID_Z_MAX) : cells_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_x <= CELLS_RESET;
      cells_y <= CELLS_RESET;
      cells_z <= CELLS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_X: cells_x <= cfg_data;
        REG_CELLS_Y: cells_y <= cfg_data;
        REG_CELLS_Z: cells_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // control store lookup
  assign uword     = ucode(step);
  assign finish_go = (state == S_RUN) && (uword.op == OP_FINISH) && (!out_valid || out_ready);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_RUN;
      S_RUN:  if (finish_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_RUN:   in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  // step sequencing with conditional jumps
  always_comb begin
    step_next = step + STEP_W'(1);
    unique case (uword.op)
      OP_DISPATCH: if (!n_inside || cmd_q == CMD_WRITE) step_next = uword.target;
      OP_READ:     step_next = step + STEP_W'(1);
      OP_NOP:      step_next = step + STEP_W'(1);
      OP_FINISH:   step_next = finish_go ? uword.target : step;
      default:     step_next = uword.target;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= STEP_DISPATCH;
    end else begin
      state <= state_next;
      if (in_fire) begin
        step <= STEP_DISPATCH;
      end else if (state == S_RUN) begin
        step <= step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q  <= command;
      x_q    <= cell_x;
      y_q    <= cell_y;
      z_q    <= cell_z;
      occ_q  <= occupancy_in;
      comp_q <= component_in[COMP_W-1:0];
    end
  end

  // offset coordinates and grid test, the dispatch step uses the center itself
  assign nx = $signed({2'b00, x_q}) + NCOORD_W'(uword.dx);
  assign ny = $signed({2'b00, y_q}) + NCOORD_W'(uword.dy);
  assign nz = $signed({2'b00, z_q}) + NCOORD_W'(uword.dz);

  assign n_inside = !nx[NCOORD_W-1] && !ny[NCOORD_W-1] && !nz[NCOORD_W-1] &&
                    (nx[NCOORD_W-2:0] < {1'b0, lim_x}) &&
                    (ny[NCOORD_W-2:0] < {1'b0, lim_y}) &&
                    (nz[NCOORD_W-2:0] < {1'b0, lim_z});

  assign ram_addr  = addr_of(nx[COORD_W-1:0], ny[COORD_W-1:0], nz[COORD_W-1:0]);
  assign ram_wdata = {occ_q, comp_q};
  assign ram_we    = (state == S_RUN) && (uword.op == OP_DISPATCH) &&
                     (cmd_q == CMD_WRITE) && n_inside;

  vnsq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // tag each read so its data is judged the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else begin
      ev_valid <= (state == S_RUN) &&
                  ((uword.op == OP_READ) ||
                   (uword.op == OP_DISPATCH && cmd_q == CMD_QUERY && n_inside));
    end
  end

  always_ff @(posedge clk) begin
    ev_center <= (uword.op == OP_DISPATCH);
    ev_face   <= uword.face;
    ev_inside <= n_inside;
  end

  assign rd_class = occ_class(ram_rdata[WORD_W-1:COMP_W]);
  assign rd_comp  = ram_rdata[COMP_W-1:0];

  // accumulate the three checks over the neighbor reads
  always_ff @(posedge clk) begin
    if (rst || in_fire) begin
      occ_surf_q  <= 1'b0;
      comp_surf_q <= 1'b0;
      diff_q      <= '0;
    end else begin
      if (state == S_RUN && uword.op == OP_DISPATCH) begin
        ing_q <= n_inside;
      end
      if (ev_valid && ev_center) begin
        my_class <= rd_class;
        my_comp  <= rd_comp;
      end
      if (ev_valid && !ev_center && ev_inside && rd_class != my_class) begin
        occ_surf_q <= 1'b1;
      end
      if (ev_valid && ev_face && !ev_inside) begin
        // face on the grid border
        comp_surf_q <= 1'b1;
      end
      if (ev_valid && ev_face && ev_inside && rd_comp != my_comp) begin
        comp_surf_q <= 1'b1;
        diff_q      <= diff_q + DIFF_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      in_grid           <= ing_q;
      occupancy_surface <= occ_surf_q;
      component_surface <= comp_surf_q;
      differing_faces   <= diff_q;
      candidate_corner  <= (diff_q >= DIFF_W'(2));
    end
  end

`include "voxel_neighborhood_surface_query_assert.svh"

  `VNSQ_ASSERT_IMPLIES(a_write_only_at_dispatch, ram_we, uword.op == OP_DISPATCH && cmd_q == CMD_WRITE, "voxel write outside the dispatch step")
  `VNSQ_ASSERT_ALWAYS(a_diff_bounded, diff_q <= DIFF_W'(6), "more than six differing faces")
  `VNSQ_ASSERT_IMPLIES(a_corner_matches, out_valid, candidate_corner == (differing_faces >= DIFF_W'(2)), "corner flag disagrees with face count")
  `VNSQ_ASSERT_IMPLIES(a_off_grid_clean, out_valid && !in_grid, !occupancy_surface && !component_surface && differing_faces == '0, "flags set on an off-grid result")
  `VNSQ_ASSERT_NEXT(a_accept_starts, in_fire, state == S_RUN && step == STEP_DISPATCH, "accepted beat did not start the program")

endmodule

### rtl/vnsq_ram.sv
// generic single-port ram, one read or write per cycle, registered read data
// no dependencies
module vnsq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
